FILE: src/srdt_pkg.sv
// ----------------------------------------------------------------------------
// srdt_pkg
// Shared constants, field widths and control types for the scan report
// device table.
// ----------------------------------------------------------------------------
package srdt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int ADDR_W  = 48;
  localparam int STR_W   = 8;
  localparam int SCAN_W  = 16;
  localparam int INDEX_W = 4;
  localparam int ACT_W   = 2;
  localparam int USED_W  = 5;

  localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_AVERAGE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REPLACE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DROP    = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]        addr;
    logic [SCAN_W-1:0]        scan;
    logic signed [STR_W-1:0]  strength;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic search;
    logic update;
    logic insert;
    logic drop;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic last;
  } dp_sts_t;

endpackage

FILE: src/srdt_ctrl.sv
// ----------------------------------------------------------------------------
// srdt_ctrl
// Controller: accepts a report, sequences the table search and chooses
// between update, insertion and drop.
// ----------------------------------------------------------------------------
module srdt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output srdt_pkg::dp_cmd_t cmd,
  input  srdt_pkg::dp_sts_t sts
);
  import srdt_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_INSERT = 3'd3;
  localparam logic [2:0] ST_DROP   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (sts.full) begin
            state_nxt = ST_DROP;
          end else if (sts.empty) begin
            state_nxt = ST_INSERT;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (sts.hit) begin
          state_nxt = ST_UPDATE;
        end else if (sts.last) begin
          state_nxt = ST_INSERT;
        end
      end
      ST_UPDATE: state_nxt = ST_IDLE;
      ST_INSERT: state_nxt = ST_IDLE;
      ST_DROP:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && start;
  assign cmd.search = (state_r == ST_SEARCH);
  assign cmd.update = (state_r == ST_UPDATE);
  assign cmd.insert = (state_r == ST_INSERT);
  assign cmd.drop   = (state_r == ST_DROP);

  // A report taken from idle always leaves idle on the next edge.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> busy)
    else $error("controller stayed idle after accepting a report");

  // A hit during the search always leads to an update.
  a_hit_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH && sts.hit) |=> (state_r == ST_UPDATE))
    else $error("search hit did not lead to an update");

  // The table is never both full and empty.
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.full && sts.empty))
    else $error("table reported full and empty together");

endmodule

FILE: src/srdt_dpath.sv
// ----------------------------------------------------------------------------
// srdt_dpath
// Datapath: report registers, entry memory with registered read, search
// pointer, address compare, strength averaging and result registers.
// ----------------------------------------------------------------------------
module srdt_dpath #(
  parameter int TABLE_DEPTH = srdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  srdt_pkg::dp_cmd_t                 cmd,
  output srdt_pkg::dp_sts_t                 sts,
  input  logic [srdt_pkg::ADDR_W-1:0]       in_device_address,
  input  logic signed [srdt_pkg::STR_W-1:0] in_signal_strength,
  input  logic [srdt_pkg::SCAN_W-1:0]       in_scan_number,
  output logic                              out_valid,
  output logic [srdt_pkg::INDEX_W-1:0]      out_entry_index,
  output logic [srdt_pkg::ACT_W-1:0]        out_action_taken,
  output logic signed [srdt_pkg::STR_W-1:0] out_stored_strength,
  output logic [srdt_pkg::USED_W-1:0]       out_entries_used
);
  import srdt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // Captured report.
  logic [ADDR_W-1:0]       in_addr_r;
  logic signed [STR_W-1:0] in_str_r;
  logic [SCAN_W-1:0]       in_scan_r;

  // Table storage and search state.
  entry_t           table_mem [TABLE_DEPTH];
  entry_t           rd_entry_r;
  logic [IDX_W-1:0] rd_ptr_r;
  logic [IDX_W-1:0] cmp_ptr_r;
  logic             cmp_vld_r;
  logic [CNT_W-1:0] count_r;

  // Result registers.
  logic                    out_valid_r;
  logic [IDX_W-1:0]        res_idx_r;
  logic [ACT_W-1:0]        res_act_r;
  logic signed [STR_W-1:0] res_str_r;

  logic                    hit;
  logic                    rd_en;
  logic                    scan_eq;
  logic [STR_W:0]          sum;
  logic [STR_W:0]          sum_adj;
  logic signed [STR_W-1:0] avg;
  logic signed [STR_W-1:0] str_new;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;
  entry_t                  wr_entry;

  assign hit     = cmp_vld_r && (rd_entry_r.addr == in_addr_r);
  assign rd_en   = cmd.search && !hit && (CNT_W'(rd_ptr_r) < count_r);
  assign scan_eq = (rd_entry_r.scan == in_scan_r);

  // Halving toward zero: add one to a negative sum before the shift.
  assign sum     = {rd_entry_r.strength[STR_W-1], rd_entry_r.strength}
                 + {in_str_r[STR_W-1], in_str_r};
  assign sum_adj = sum + (STR_W+1)'(sum[STR_W]);
  assign avg     = sum_adj[STR_W:1];

  assign str_new  = (cmd.update && scan_eq) ? avg : in_str_r;
  assign wr_en    = cmd.update || cmd.insert;
  assign wr_idx   = cmd.update ? cmp_ptr_r : IDX_W'(count_r);
  assign wr_entry = '{addr: in_addr_r, scan: in_scan_r, strength: str_new};

  assign sts.full  = (count_r == DEPTH_C);
  assign sts.empty = (count_r == '0);
  assign sts.hit   = hit;
  assign sts.last  = cmp_vld_r && ((CNT_W'(cmp_ptr_r) + 1'b1) == count_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= table_mem[rd_ptr_r];
      cmp_ptr_r  <= rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_addr_r <= in_device_address;
      in_str_r  <= in_signal_strength;
      in_scan_r <= in_scan_number;
    end
    if (cmd.update) begin
      res_idx_r <= cmp_ptr_r;
      res_act_r <= scan_eq ? ACT_AVERAGE : ACT_REPLACE;
      res_str_r <= str_new;
    end else if (cmd.insert) begin
      res_idx_r <= IDX_W'(count_r);
      res_act_r <= ACT_INSERT;
      res_str_r <= str_new;
    end else if (cmd.drop) begin
      res_idx_r <= '0;
      res_act_r <= ACT_DROP;
      res_str_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_ptr_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update || cmd.insert || cmd.drop;
      if (cmd.insert) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.load) begin
        rd_ptr_r  <= '0;
        cmp_vld_r <= 1'b0;
      end else begin
        cmp_vld_r <= rd_en;
        if (rd_en) begin
          rd_ptr_r <= rd_ptr_r + 1'b1;
        end
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_entry_index     = INDEX_W'(res_idx_r);
  assign out_action_taken    = res_act_r;
  assign out_stored_strength = res_str_r;
  assign out_entries_used    = USED_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count exceeds the table depth");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("insertion did not advance the entry count");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == DEPTH_C) |-> !wr_en)
    else $error("table written while full");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

endmodule

FILE: src/scan_report_device_table.sv
// ----------------------------------------------------------------------------
// scan_report_device_table
// Keeps a table of seen devices from parsed scan reports: averages, replaces,
// appends or drops, and reports one result for every report.
//
//   Channel  Handshake                 Payload
//   -------  ------------------------  --------------------------------------
//   input    start / busy              in_device_address, in_signal_strength,
//                                      in_scan_number
//   result   out_valid (1-cycle pulse) out_entry_index, out_action_taken,
//                                      out_stored_strength, out_entries_used
//
// A report is transferred when start is high and busy is low. The search
// reads one entry per cycle from the entry memory and stops at a hit, which
// leads to an update, or when the last valid entry misses, which leads to
// an insert. A full table drops the report and an empty one inserts it
// without a search, and the result strobe is registered from that step.
// Synchronous reset empties the table; entries need no clearing.
// The result receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module scan_report_device_table #(
  parameter int TABLE_DEPTH = srdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [srdt_pkg::ADDR_W-1:0]       in_device_address,
  input  logic signed [srdt_pkg::STR_W-1:0] in_signal_strength,
  input  logic [srdt_pkg::SCAN_W-1:0]       in_scan_number,
  output logic                              out_valid,
  output logic [srdt_pkg::INDEX_W-1:0]      out_entry_index,
  output logic [srdt_pkg::ACT_W-1:0]        out_action_taken,
  output logic signed [srdt_pkg::STR_W-1:0] out_stored_strength,
  output logic [srdt_pkg::USED_W-1:0]       out_entries_used
);
  import srdt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  srdt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  srdt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_device_address   (in_device_address),
    .in_signal_strength  (in_signal_strength),
    .in_scan_number      (in_scan_number),
    .out_valid           (out_valid),
    .out_entry_index     (out_entry_index),
    .out_action_taken    (out_action_taken),
    .out_stored_strength (out_stored_strength),
    .out_entries_used    (out_entries_used)
  );

endmodule
